// File: hdl/kscd_pkg.sv
// Shared types, scan codes and the ASCII lookup for the scan code decoder.
package kscd_pkg;

  localparam int KSCD_QUEUE_DEPTH = 16;

  // Set 2 codes that steer the decoder instead of making an event.
  localparam logic [7:0] CODE_RELEASE = 8'hF0;
  localparam logic [7:0] CODE_LSHIFT  = 8'h12;
  localparam logic [7:0] CODE_RSHIFT  = 8'h59;
  localparam logic [7:0] CODE_ALT     = 8'h11;
  localparam logic [7:0] CODE_CTRL    = 8'h14;
  localparam logic [7:0] CODE_CAPS    = 8'h58;

  typedef struct packed {
    logic [7:0] ascii;
    logic [7:0] code;
    logic       caps;
    logic       shift;
    logic       alt;
    logic       ctrl;
    logic       rel;
  } kscd_event_t;

  // Status of a pop that waits for its queue read data.
  typedef struct packed {
    logic hit;
    logic overflowed;
  } kscd_pop_t;

  function automatic logic [7:0] kscd_pick(input logic shifted, input logic [7:0] lo,
                                           input logic [7:0] hi);
    kscd_pick = shifted ? hi : lo;
  endfunction

  // ASCII for a scan code; codes outside the table map to zero.
  function automatic logic [7:0] kscd_ascii(input logic shifted, input logic [7:0] code);
    logic [7:0] ch;
    ch = 8'h00;
    case (code)
      8'h0D: ch = 8'h09;
      8'h0E: ch = kscd_pick(shifted, 8'h60, 8'h7E);
      8'h15: ch = kscd_pick(shifted, "q", "Q");
      8'h16: ch = kscd_pick(shifted, "1", "!");
      8'h1A: ch = kscd_pick(shifted, "z", "Z");
      8'h1B: ch = kscd_pick(shifted, "s", "S");
      8'h1C: ch = kscd_pick(shifted, "a", "A");
      8'h1D: ch = kscd_pick(shifted, "w", "W");
      8'h1E: ch = kscd_pick(shifted, "2", "@");
      8'h21: ch = kscd_pick(shifted, "c", "C");
      8'h22: ch = kscd_pick(shifted, "x", "X");
      8'h23: ch = kscd_pick(shifted, "d", "D");
      8'h24: ch = kscd_pick(shifted, "e", "E");
      8'h25: ch = kscd_pick(shifted, "4", "$");
      8'h26: ch = kscd_pick(shifted, "3", "#");
      8'h29: ch = 8'h20;
      8'h2A: ch = kscd_pick(shifted, "v", "V");
      8'h2B: ch = kscd_pick(shifted, "f", "F");
      8'h2C: ch = kscd_pick(shifted, "t", "T");
      8'h2D: ch = kscd_pick(shifted, "r", "R");
      8'h2E: ch = kscd_pick(shifted, "5", "%");
      8'h31: ch = kscd_pick(shifted, "n", "N");
      8'h32: ch = kscd_pick(shifted, "b", "B");
      8'h33: ch = kscd_pick(shifted, "h", "H");
      8'h34: ch = kscd_pick(shifted, "g", "G");
      8'h35: ch = kscd_pick(shifted, "y", "Y");
      8'h36: ch = kscd_pick(shifted, "6", "^");
      8'h3A: ch = kscd_pick(shifted, "m", "M");
      8'h3B: ch = kscd_pick(shifted, "j", "J");
      8'h3C: ch = kscd_pick(shifted, "u", "U");
      8'h3D: ch = kscd_pick(shifted, "7", "&");
      8'h3E: ch = kscd_pick(shifted, "8", "*");
      8'h41: ch = kscd_pick(shifted, ",", "<");
      8'h42: ch = kscd_pick(shifted, "k", "K");
      8'h43: ch = kscd_pick(shifted, "i", "I");
      8'h44: ch = kscd_pick(shifted, "o", "O");
      8'h45: ch = kscd_pick(shifted, "0", ")");
      8'h46: ch = kscd_pick(shifted, "9", "(");
      8'h49: ch = kscd_pick(shifted, ".", ">");
      8'h4A: ch = kscd_pick(shifted, "/", "?");
      8'h4B: ch = kscd_pick(shifted, "l", "L");
      8'h4C: ch = kscd_pick(shifted, ";", ":");
      8'h4D: ch = kscd_pick(shifted, "p", "P");
      8'h4E: ch = kscd_pick(shifted, "-", "_");
      8'h52: ch = kscd_pick(shifted, 8'h27, 8'h22);
      8'h54: ch = kscd_pick(shifted, "[", "{");
      8'h55: ch = kscd_pick(shifted, "=", "+");
      8'h5A: ch = 8'h0A;
      8'h5B: ch = kscd_pick(shifted, "]", "}");
      8'h66: ch = 8'h08;
      8'h69: ch = "1";
      8'h6B: ch = "4";
      8'h6C: ch = "7";
      8'h70: ch = "0";
      8'h71: ch = ".";
      8'h72: ch = "2";
      8'h73: ch = "5";
      8'h74: ch = "6";
      8'h75: ch = "8";
      8'h79: ch = "+";
      8'h7A: ch = "3";
      8'h7B: ch = "-";
      8'h7C: ch = "*";
      8'h7D: ch = "9";
      default: ch = 8'h00;
    endcase
    kscd_ascii = ch;
  endfunction

endpackage

// File: hdl/keyboard_scan_code_decoder_core.sv
// Top level of the set 2 scan code decoder with its key event queue.
// Each input beat is either a scan code byte or a pop request, and one beat is taken
// every cycle while the output side keeps up. A scan code updates the modifier and
// release state and, for an ordinary key, pushes an event into a QUEUE_DEPTH-entry
// RAM in the same cycle; it makes no result. A pop makes exactly one result: the RAM read
// and the pop status are registered in the read stage, then loaded into the output
// register when it is free. When the output register is held by a stalled consumer,
// one more pop can wait in the read stage and then the input stalls. A full queue
// drops the event and sets a sticky overflow flag.
module keyboard_scan_code_decoder_core import kscd_pkg::*; #(
  parameter int QUEUE_DEPTH = KSCD_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       req_type,
  input  logic [7:0] code_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       event_valid,
  output logic [7:0] ascii_char,
  output logic [7:0] event_code,
  output logic       caps_active,
  output logic       shift_held,
  output logic       alt_held,
  output logic       ctrl_held,
  output logic       is_release,
  output logic       overflowed
);

  logic        in_beat, code_valid, pop, advance;
  logic        push, pend_valid;
  kscd_event_t push_event, pend_event, shown;
  kscd_pop_t   pend;

  assign advance    = ~out_valid | out_ready;
  assign in_ready   = ~pend_valid | advance;
  assign in_beat    = in_valid & in_ready;
  assign code_valid = in_beat & ~req_type;
  assign pop        = in_beat & req_type;

  kscd_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .code_valid (code_valid),
    .code_byte  (code_byte),
    .push       (push),
    .push_event (push_event)
  );

  kscd_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_event (push_event),
    .pop        (pop),
    .advance    (advance),
    .pend_valid (pend_valid),
    .pend       (pend),
    .pend_event (pend_event)
  );

  // An empty pop reports all event fields as zero.
  assign shown = pend.hit ? pend_event : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= pend_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && pend_valid) begin
      event_valid <= pend.hit;
      ascii_char  <= shown.ascii;
      event_code  <= shown.code;
      caps_active <= shown.caps;
      shift_held  <= shown.shift;
      alt_held    <= shown.alt;
      ctrl_held   <= shown.ctrl;
      is_release  <= shown.rel;
      overflowed  <= pend.overflowed;
    end
  end

  a_pop_reaches_stage: assert property (@(posedge clk) disable iff (rst)
    pop |=> pend_valid)
    else $error("pop beat did not enter the read stage");

  a_empty_pop_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !event_valid |-> ascii_char == 8'h00 && event_code == 8'h00 &&
      !is_release && !caps_active && !shift_held && !alt_held && !ctrl_held)
    else $error("empty pop carries nonzero event fields");

  a_overflow_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && overflowed |=> !out_valid || overflowed)
    else $error("overflow flag cleared without reset");

endmodule

// File: hdl/kscd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module kscd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/kscd_decode.sv
// Scan code interpreter: modifier and release state, ASCII lookup, event build.
module kscd_decode import kscd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        code_valid,
  input  logic [7:0]  code_byte,
  output logic        push,
  output kscd_event_t push_event
);

  logic release_pending, release_pending_next;
  logic shift_state, shift_state_next;
  logic alt_state, alt_state_next;
  logic ctrl_state, ctrl_state_next;
  logic caps_state, caps_state_next;
  logic press;

  assign press = ~release_pending;

  always_comb begin
    release_pending_next = release_pending;
    shift_state_next     = shift_state;
    alt_state_next       = alt_state;
    ctrl_state_next      = ctrl_state;
    caps_state_next      = caps_state;
    push                 = 1'b0;
    if (code_valid) begin
      release_pending_next = 1'b0;
      case (code_byte)
        CODE_RELEASE: release_pending_next = 1'b1;
        CODE_LSHIFT, CODE_RSHIFT: shift_state_next = press;
        CODE_ALT: alt_state_next = press;
        CODE_CTRL: ctrl_state_next = press;
        // Caps lock toggles on the make code only.
        CODE_CAPS: caps_state_next = caps_state ^ press;
        default: push = 1'b1;
      endcase
    end
  end

  always_comb begin
    push_event.ascii = kscd_ascii(shift_state | caps_state, code_byte);
    push_event.code  = code_byte;
    push_event.caps  = caps_state;
    push_event.shift = shift_state;
    push_event.alt   = alt_state;
    push_event.ctrl  = ctrl_state;
    push_event.rel   = release_pending;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      release_pending <= 1'b0;
      shift_state     <= 1'b0;
      alt_state       <= 1'b0;
      ctrl_state      <= 1'b0;
      caps_state      <= 1'b0;
    end else begin
      release_pending <= release_pending_next;
      shift_state     <= shift_state_next;
      alt_state       <= alt_state_next;
      ctrl_state      <= ctrl_state_next;
      caps_state      <= caps_state_next;
    end
  end

endmodule

// File: hdl/kscd_queue.sv
// Event queue: pointers, fill count, sticky drop flag and the pending pop stage.
module kscd_queue import kscd_pkg::*; #(
  parameter int QUEUE_DEPTH = KSCD_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  kscd_event_t push_event,
  input  logic        pop,
  input  logic        advance,
  output logic        pend_valid,
  output kscd_pop_t   pend,
  output kscd_event_t pend_event
);

  localparam int PtrW   = $clog2(QUEUE_DEPTH);
  localparam int CountW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0]   LastSlot = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CountW-1:0] FullCount = CountW'(QUEUE_DEPTH);

  logic [PtrW-1:0]   write_index, write_index_next;
  logic [PtrW-1:0]   read_index, read_index_next;
  logic [CountW-1:0] event_count, event_count_next;
  logic              drop_flag, drop_flag_next;
  logic              pend_valid_next;
  kscd_pop_t         pend_next;
  logic              full, hit, do_write, do_read;

  assign full     = (event_count == FullCount);
  assign hit      = (event_count != '0);
  assign do_write = push & ~full;
  assign do_read  = pop & hit;

  always_comb begin
    write_index_next = write_index;
    read_index_next  = read_index;
    event_count_next = event_count;
    drop_flag_next   = drop_flag | (push & full);
    if (do_write) begin
      write_index_next = (write_index == LastSlot) ? '0 : write_index + 1'b1;
      event_count_next = event_count + 1'b1;
    end
    if (do_read) begin
      read_index_next  = (read_index == LastSlot) ? '0 : read_index + 1'b1;
      event_count_next = event_count - 1'b1;
    end
  end

  // The drop flag is sampled when the pop is taken, not when its data returns.
  always_comb begin
    pend_valid_next = pend_valid;
    pend_next       = pend;
    if (pop) begin
      pend_valid_next      = 1'b1;
      pend_next.hit        = hit;
      pend_next.overflowed = drop_flag;
    end else if (advance) begin
      pend_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
      read_index  <= '0;
      event_count <= '0;
      drop_flag   <= 1'b0;
      pend_valid  <= 1'b0;
    end else begin
      write_index <= write_index_next;
      read_index  <= read_index_next;
      event_count <= event_count_next;
      drop_flag   <= drop_flag_next;
      pend_valid  <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pend <= pend_next;
  end

  kscd_ram #(
    .WIDTH($bits(kscd_event_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (do_write),
    .wr_addr (write_index),
    .wr_data (push_event),
    .rd_en   (do_read),
    .rd_addr (read_index),
    .rd_data (pend_event)
  );

endmodule

// File: sim/testbench.sv
// Self-checking testbench for the set 2 scan code decoder and its key event queue.
module testbench import kscd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int STIM_BEATS     = 700;

  // Pop results as the block reports them: a popped event plus the sticky drop flag.
  typedef struct packed {
    logic        event_valid;
    kscd_event_t ev;
    logic        overflowed;
  } key_result_t;

  typedef struct {
    logic        pop;
    logic [7:0]  code;
    int unsigned gap;
    bit          drain;
  } kb_beat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       req_type = 1'b0;
  logic [7:0] code_byte = 8'h00;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic       event_valid;
  logic [7:0] ascii_char;
  logic [7:0] event_code;
  logic       caps_active;
  logic       shift_held;
  logic       alt_held;
  logic       ctrl_held;
  logic       is_release;
  logic       overflowed;

  // Decoder state as predicted from the accepted beats.
  logic        release_armed = 1'b0;
  logic        shift_down = 1'b0;
  logic        alt_down = 1'b0;
  logic        ctrl_down = 1'b0;
  logic        caps_on = 1'b0;
  logic        drop_seen = 1'b0;
  kscd_event_t key_fifo[$];

  key_result_t pending_results[$];
  kb_beat_t    beats_to_send[$];

  int gap_count = 0;
  int stall_left = 0;
  int beats_done = 0;
  int results_seen = 0;
  int events_popped = 0;
  int mismatches = 0;
  int idle_cycles = 0;

  keyboard_scan_code_decoder_core u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .code_byte  (code_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .event_valid(event_valid),
    .ascii_char (ascii_char),
    .event_code (event_code),
    .caps_active(caps_active),
    .shift_held (shift_held),
    .alt_held   (alt_held),
    .ctrl_held  (ctrl_held),
    .is_release (is_release),
    .overflowed (overflowed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Character for a key: each entry holds the plain character in the upper byte and
  // the shifted one in the lower byte.
  function automatic logic [7:0] keymap_char(input logic upper, input logic [7:0] code);
    logic [15:0] pair;
    pair = 16'h0000;
    case (code)
      8'h0D: pair = {8'h09, 8'h09};
      8'h0E: pair = {8'h60, 8'h7E};
      8'h15: pair = {"q", "Q"};
      8'h16: pair = {"1", "!"};
      8'h1A: pair = {"z", "Z"};
      8'h1B: pair = {"s", "S"};
      8'h1C: pair = {"a", "A"};
      8'h1D: pair = {"w", "W"};
      8'h1E: pair = {"2", "@"};
      8'h21: pair = {"c", "C"};
      8'h22: pair = {"x", "X"};
      8'h23: pair = {"d", "D"};
      8'h24: pair = {"e", "E"};
      8'h25: pair = {"4", "$"};
      8'h26: pair = {"3", "#"};
      8'h29: pair = {" ", " "};
      8'h2A: pair = {"v", "V"};
      8'h2B: pair = {"f", "F"};
      8'h2C: pair = {"t", "T"};
      8'h2D: pair = {"r", "R"};
      8'h2E: pair = {"5", "%"};
      8'h31: pair = {"n", "N"};
      8'h32: pair = {"b", "B"};
      8'h33: pair = {"h", "H"};
      8'h34: pair = {"g", "G"};
      8'h35: pair = {"y", "Y"};
      8'h36: pair = {"6", "^"};
      8'h3A: pair = {"m", "M"};
      8'h3B: pair = {"j", "J"};
      8'h3C: pair = {"u", "U"};
      8'h3D: pair = {"7", "&"};
      8'h3E: pair = {"8", "*"};
      8'h41: pair = {",", "<"};
      8'h42: pair = {"k", "K"};
      8'h43: pair = {"i", "I"};
      8'h44: pair = {"o", "O"};
      8'h45: pair = {"0", ")"};
      8'h46: pair = {"9", "("};
      8'h49: pair = {".", ">"};
      8'h4A: pair = {"/", "?"};
      8'h4B: pair = {"l", "L"};
      8'h4C: pair = {";", ":"};
      8'h4D: pair = {"p", "P"};
      8'h4E: pair = {"-", "_"};
      8'h52: pair = {8'h27, 8'h22};
      8'h54: pair = {"[", "{"};
      8'h55: pair = {"=", "+"};
      8'h5A: pair = {8'h0A, 8'h0A};
      8'h5B: pair = {"]", "}"};
      8'h66: pair = {8'h08, 8'h08};
      8'h69: pair = {"1", "1"};
      8'h6B: pair = {"4", "4"};
      8'h6C: pair = {"7", "7"};
      8'h70: pair = {"0", "0"};
      8'h71: pair = {".", "."};
      8'h72: pair = {"2", "2"};
      8'h73: pair = {"5", "5"};
      8'h74: pair = {"6", "6"};
      8'h75: pair = {"8", "8"};
      8'h79: pair = {"+", "+"};
      8'h7A: pair = {"3", "3"};
      8'h7B: pair = {"-", "-"};
      8'h7C: pair = {"*", "*"};
      8'h7D: pair = {"9", "9"};
      default: pair = 16'h0000;
    endcase
    return upper ? pair[7:0] : pair[15:8];
  endfunction

  // Applies one accepted beat to the predicted state; a pop queues its expected result.
  task automatic decode_beat(input logic is_pop, input logic [7:0] code);
    kscd_event_t ev;
    key_result_t res;
    logic        pressed;
    if (is_pop) begin
      res = '0;
      if (key_fifo.size() != 0) begin
        res.ev = key_fifo.pop_front();
        res.event_valid = 1'b1;
        events_popped++;
      end
      res.overflowed = drop_seen;
      pending_results.push_back(res);
    end else begin
      pressed = !release_armed;
      if (code == CODE_RELEASE) begin
        release_armed = 1'b1;
      end else begin
        if (code == CODE_LSHIFT || code == CODE_RSHIFT) begin
          shift_down = pressed;
        end else if (code == CODE_ALT) begin
          alt_down = pressed;
        end else if (code == CODE_CTRL) begin
          ctrl_down = pressed;
        end else if (code == CODE_CAPS) begin
          if (pressed) caps_on = !caps_on;
        end else begin
          ev.ascii = keymap_char(shift_down || caps_on, code);
          ev.code  = code;
          ev.caps  = caps_on;
          ev.shift = shift_down;
          ev.alt   = alt_down;
          ev.ctrl  = ctrl_down;
          ev.rel   = release_armed;
          if (key_fifo.size() >= KSCD_QUEUE_DEPTH) drop_seen = 1'b1;
          else key_fifo.push_back(ev);
        end
        release_armed = 1'b0;
      end
    end
  endtask

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  // Sender idling runs in stretches of 40 beats: one stretch in three has no gaps.
  task automatic add_beat(input logic pop, input logic [7:0] code, input bit drain);
    kb_beat_t b;
    b.pop   = pop;
    b.code  = code;
    b.drain = drain;
    b.gap   = ((beats_to_send.size() / 40) % 3 == 0) ? 0 : $urandom_range(0, 14);
    beats_to_send.push_back(b);
  endtask

  function automatic logic [7:0] pick_code();
    return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) :
                                         8'($urandom_range(0, 143));
  endfunction

  always @(posedge clk) begin : drive_beats
    kb_beat_t nxt;
    logic     hold;
    logic     launch;
    if (rst) begin
      in_valid  <= 1'b0;
      req_type  <= 1'b0;
      code_byte <= 8'h00;
      gap_count = 0;
    end else begin
      hold = in_valid;
      launch = 1'b0;
      if (in_valid && in_ready) begin
        decode_beat(req_type, code_byte);
        beats_done++;
        hold = 1'b0;
      end
      // A draining beat is held back until every pop already sent has returned.
      if (!hold && beats_to_send.size() != 0 &&
          !(beats_to_send[0].drain && pending_results.size() != 0)) begin
        if (gap_count < beats_to_send[0].gap) begin
          gap_count++;
        end else begin
          nxt = beats_to_send.pop_front();
          launch = 1'b1;
          gap_count = 0;
        end
      end
      in_valid <= hold || launch;
      if (launch) begin
        req_type  <= nxt.pop;
        code_byte <= nxt.code;
      end
    end
  end

  always @(posedge clk) begin : take_results
    key_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $display("%0t ns: result beat with no expectation waiting, event_code %0d",
                   $time, event_code);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("event_valid", want.event_valid, event_valid);
          check_field("ascii_char", want.ev.ascii, ascii_char);
          check_field("event_code", want.ev.code, event_code);
          check_field("caps_active", want.ev.caps, caps_active);
          check_field("shift_held", want.ev.shift, shift_held);
          check_field("alt_held", want.ev.alt, alt_held);
          check_field("ctrl_held", want.ev.ctrl, ctrl_held);
          check_field("is_release", want.ev.rel, is_release);
          check_field("overflowed", want.overflowed, overflowed);
        end
        stall_left = ((results_seen / 35) % 3 == 1) ? 0 : $urandom_range(0, 14);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_ready <= (stall_left == 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t ns: no beat moved for %0d cycles", $time, idle_cycles);
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin : run
    int          r;
    int          n;
    logic [7:0]  mods[4];
    bit          flood_done;
    mods = '{CODE_LSHIFT, CODE_RSHIFT, CODE_ALT, CODE_CTRL};
    flood_done = 1'b0;

    // Directed: empty pop, plain and shifted keys, every modifier, caps lock toggling
    // on press only, a doubled release prefix, and codes past the end of the table.
    add_beat(1'b1, 8'h00, 1'b0);
    add_beat(1'b0, 8'h1C, 1'b0);
    add_beat(1'b1, 8'hFF, 1'b0);
    add_beat(1'b0, CODE_LSHIFT, 1'b0);
    add_beat(1'b0, 8'h1C, 1'b0);
    add_beat(1'b0, CODE_RELEASE, 1'b0);
    add_beat(1'b0, CODE_LSHIFT, 1'b0);
    add_beat(1'b0, CODE_RSHIFT, 1'b0);
    add_beat(1'b0, 8'h15, 1'b0);
    add_beat(1'b0, CODE_RELEASE, 1'b0);
    add_beat(1'b0, CODE_RSHIFT, 1'b0);
    add_beat(1'b0, CODE_ALT, 1'b0);
    add_beat(1'b0, CODE_CTRL, 1'b0);
    add_beat(1'b0, 8'h0E, 1'b0);
    add_beat(1'b0, CODE_RELEASE, 1'b0);
    add_beat(1'b0, CODE_ALT, 1'b0);
    add_beat(1'b0, CODE_RELEASE, 1'b0);
    add_beat(1'b0, CODE_CTRL, 1'b0);
    add_beat(1'b0, CODE_CAPS, 1'b0);
    add_beat(1'b0, CODE_RELEASE, 1'b0);
    add_beat(1'b0, CODE_CAPS, 1'b0);
    add_beat(1'b0, 8'h1C, 1'b0);
    add_beat(1'b0, CODE_CAPS, 1'b0);
    add_beat(1'b0, CODE_RELEASE, 1'b0);
    add_beat(1'b0, CODE_RELEASE, 1'b0);
    add_beat(1'b0, 8'h1C, 1'b0);
    add_beat(1'b0, 8'h00, 1'b0);
    add_beat(1'b0, 8'h8F, 1'b0);
    add_beat(1'b0, 8'h90, 1'b0);
    add_beat(1'b0, 8'hFF, 1'b0);
    add_beat(1'b0, 8'hE0, 1'b0);
    for (int i = 0; i < 11; i++) add_beat(1'b1, 8'h00, 1'b0);

    // Random: mostly well-formed key strokes with random codes, some noise, and one
    // flood that overruns the queue well into the run.
    add_beat(1'b1, 8'h00, 1'b1);
    while (beats_to_send.size() < STIM_BEATS) begin
      if (beats_to_send.size() % 150 == 0) add_beat(1'b1, 8'($urandom_range(0, 255)), 1'b1);
      if (!flood_done && beats_to_send.size() >= 420) begin
        flood_done = 1'b1;
        for (int i = 0; i < 22; i++) add_beat(1'b0, 8'($urandom_range(0, 143)), 1'b0);
        for (int i = 0; i < 20; i++) add_beat(1'b1, 8'($urandom_range(0, 255)), 1'b0);
      end
      r = $urandom_range(0, 99);
      if (r < 30) begin
        add_beat(1'b1, 8'($urandom_range(0, 255)), 1'b0);
      end else if (r < 52) begin
        add_beat(1'b0, pick_code(), 1'b0);
      end else if (r < 68) begin
        add_beat(1'b0, CODE_RELEASE, 1'b0);
        add_beat(1'b0, pick_code(), 1'b0);
      end else if (r < 78) begin
        if ($urandom_range(0, 1) == 1) add_beat(1'b0, CODE_RELEASE, 1'b0);
        add_beat(1'b0, mods[$urandom_range(0, 3)], 1'b0);
      end else if (r < 83) begin
        add_beat(1'b0, CODE_CAPS, 1'b0);
        if ($urandom_range(0, 1) == 1) begin
          add_beat(1'b0, CODE_RELEASE, 1'b0);
          add_beat(1'b0, CODE_CAPS, 1'b0);
        end
      end else if (r < 91) begin
        n = $urandom_range(2, 4);
        for (int i = 0; i < n; i++) add_beat(1'b1, 8'($urandom_range(0, 255)), 1'b0);
      end else begin
        add_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0);
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    while (beats_to_send.size() != 0 || in_valid) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d beats and checked %0d pop results, %0d of them carrying an event.",
             beats_done, results_seen, events_popped);
    $display("Queue overflow %s; %0d mismatches.", drop_seen ? "was reached" : "not reached",
             mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
